@@ rtl/core/ess_pkg.sv @@
// ----------------------------------------------------------------------------
// ess_pkg
// Shared types and constants of the engine start sequencer.
// ----------------------------------------------------------------------------
package ess_pkg;

  localparam int unsigned TdataInW  = 80;
  localparam int unsigned TuserInW  = 3;
  localparam int unsigned TdataOutW = 16;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [9:0] ThrottleMax = 10'd1000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ENABLE        = 3'd0,
    CFG_THROTTLE_MIN  = 3'd1,
    CFG_PREP_TIMEOUT  = 3'd2,
    CFG_STARTER_HOLD  = 3'd3,
    CFG_LINK_TIMEOUT  = 3'd4,
    CFG_DAMPER_LOW    = 3'd5,
    CFG_DAMPER_HIGH   = 3'd6,
    CFG_RESTART_RPM   = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  localparam logic [1:0] PHASE_CODE_STOP    = 2'd0;
  localparam logic [1:0] PHASE_CODE_PREPARE = 2'd1;
  localparam logic [1:0] PHASE_CODE_START   = 2'd2;
  localparam logic [1:0] PHASE_CODE_RUNNING = 2'd3;

  typedef enum logic [3:0] {
    PH_STOP    = 4'b0001,
    PH_PREPARE = 4'b0010,
    PH_START   = 4'b0100,
    PH_RUNNING = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        enable;
    logic [9:0]  throttle_min;
    logic [15:0] prepare_timeout_ms;
    logic [15:0] starter_hold_ms;
    logic [15:0] link_timeout_ms;
    logic [9:0]  damper_low;
    logic [9:0]  damper_high;
    logic [15:0] restart_rpm_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               armed_flying;
    logic               vtol_mode;
    logic signed [10:0] throttle_demand;
    logic [15:0]        damper_pos;
    logic [15:0]        engine_rpm;
    logic               frame_fresh;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic       link_ok;
    logic [1:0] engine_phase;
    logic       starter_on;
    logic [9:0] throttle_out;
  } result_t;

endpackage

@@ rtl/core/ess_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ess_cfg_regs
// Configuration register file, write only, with reset values.
// ----------------------------------------------------------------------------
module ess_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ess_pkg::CfgAddrW-1:0]  wr_addr,
  input  logic [ess_pkg::CfgDataW-1:0]  wr_data,
  output ess_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable             <= 1'b0;
      cfg.throttle_min       <= 10'd0;
      cfg.prepare_timeout_ms <= 16'd2000;
      cfg.starter_hold_ms    <= 16'd2000;
      cfg.link_timeout_ms    <= 16'd1000;
      cfg.damper_low         <= 10'd230;
      cfg.damper_high        <= 10'd270;
      cfg.restart_rpm_limit  <= 16'd1000;
    end else if (wr_en) begin
      case (ess_pkg::cfg_idx_t'(wr_addr))
        ess_pkg::CFG_ENABLE:       cfg.enable             <= wr_data[0];
        ess_pkg::CFG_THROTTLE_MIN: cfg.throttle_min       <= wr_data[9:0];
        ess_pkg::CFG_PREP_TIMEOUT: cfg.prepare_timeout_ms <= wr_data;
        ess_pkg::CFG_STARTER_HOLD: cfg.starter_hold_ms    <= wr_data;
        ess_pkg::CFG_LINK_TIMEOUT: cfg.link_timeout_ms    <= wr_data;
        ess_pkg::CFG_DAMPER_LOW:   cfg.damper_low         <= wr_data[9:0];
        ess_pkg::CFG_DAMPER_HIGH:  cfg.damper_high        <= wr_data[9:0];
        ess_pkg::CFG_RESTART_RPM:  cfg.restart_rpm_limit  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/ess_core.sv @@
// ----------------------------------------------------------------------------
// ess_core
// Sequencer state and the one-tick step: phase step, frame capture, link
// check, vtol change handling and start or stop request.
// ----------------------------------------------------------------------------
module ess_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  ess_pkg::cfg_t       cfg,
  input  ess_pkg::item_t      item,
  output ess_pkg::result_t    result
);

  ess_pkg::phase_t phase, ph_step, ph_vtol, ph_next;
  logic [31:0] phase_entry_ms, ent_step, ent_vtol, phase_entry_ms_next;
  logic [31:0] last_frame_ms, last_frame_ms_next;
  logic        frame_seen, frame_seen_next;
  logic        link_flag, link_flag_next;
  logic [15:0] stored_rpm, stored_rpm_next;
  logic [15:0] stored_damper, stored_damper_next;
  logic        prev_vtol, prev_vtol_next;
  logic        vtol_captured, vtol_captured_next;

  logic [31:0] elapsed, frame_age;
  logic [9:0]  tmin, thr;
  logic        starter;
  logic        damper_ok;
  logic        rpm_ok;
  logic        vtol_start, vtol_stop;

  function automatic logic start_ok(ess_pkg::phase_t ph, logic link, logic rpm_low);
    start_ok = (ph != ess_pkg::PH_PREPARE) && (ph != ess_pkg::PH_START) &&
               (!link || rpm_low);
  endfunction

  assign elapsed   = item.now_ms - phase_entry_ms;
  assign tmin      = (cfg.throttle_min > ess_pkg::ThrottleMax) ? ess_pkg::ThrottleMax
                                                               : cfg.throttle_min;
  assign damper_ok = ({6'd0, cfg.damper_low} < stored_damper) &&
                     (stored_damper < {6'd0, cfg.damper_high});

  always_comb begin
    ph_step  = phase;
    ent_step = phase_entry_ms;
    thr      = '0;
    starter  = 1'b0;
    case (phase)
      ess_pkg::PH_PREPARE: begin
        thr = tmin;
        if ((link_flag && damper_ok) || (elapsed > {16'd0, cfg.prepare_timeout_ms})) begin
          ph_step  = ess_pkg::PH_START;
          ent_step = item.now_ms;
        end
      end
      ess_pkg::PH_START: begin
        thr     = tmin;
        starter = 1'b1;
        if (elapsed > {16'd0, cfg.starter_hold_ms}) begin
          ph_step  = ess_pkg::PH_RUNNING;
          ent_step = item.now_ms;
        end
      end
      ess_pkg::PH_RUNNING: begin
        if (item.throttle_demand < $signed({1'b0, tmin})) begin
          thr = tmin;
        end else if (item.throttle_demand > $signed({1'b0, ess_pkg::ThrottleMax})) begin
          thr = ess_pkg::ThrottleMax;
        end else begin
          thr = item.throttle_demand[9:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (item.frame_fresh) begin
      last_frame_ms_next = item.now_ms;
      frame_seen_next    = 1'b1;
      stored_rpm_next    = item.engine_rpm;
      stored_damper_next = item.damper_pos;
    end else begin
      last_frame_ms_next = last_frame_ms;
      frame_seen_next    = frame_seen;
      stored_rpm_next    = stored_rpm;
      stored_damper_next = stored_damper;
    end
  end

  assign frame_age      = item.now_ms - last_frame_ms_next;
  assign link_flag_next = frame_seen_next && (frame_age <= {16'd0, cfg.link_timeout_ms});
  assign rpm_ok         = stored_rpm_next < cfg.restart_rpm_limit;

  assign vtol_start = vtol_captured && (prev_vtol != item.vtol_mode) &&
                      item.armed_flying && !item.vtol_mode;
  assign vtol_stop  = vtol_captured && (prev_vtol != item.vtol_mode) &&
                      item.armed_flying && item.vtol_mode;
  assign prev_vtol_next     = item.vtol_mode;
  assign vtol_captured_next = 1'b1;

  always_comb begin
    ph_vtol  = ph_step;
    ent_vtol = ent_step;
    if (vtol_stop && (ph_step != ess_pkg::PH_STOP)) begin
      ph_vtol  = ess_pkg::PH_STOP;
      ent_vtol = item.now_ms;
    end else if (vtol_start && start_ok(ph_step, link_flag_next, rpm_ok)) begin
      ph_vtol  = ess_pkg::PH_PREPARE;
      ent_vtol = item.now_ms;
    end
  end

  always_comb begin
    ph_next             = ph_vtol;
    phase_entry_ms_next = ent_vtol;
    case (item.req_type)
      ess_pkg::REQ_START: begin
        if (start_ok(ph_vtol, link_flag_next, rpm_ok)) begin
          ph_next             = ess_pkg::PH_PREPARE;
          phase_entry_ms_next = item.now_ms;
        end
      end
      ess_pkg::REQ_STOP: begin
        if (ph_vtol != ess_pkg::PH_STOP) begin
          ph_next             = ess_pkg::PH_STOP;
          phase_entry_ms_next = item.now_ms;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ess_pkg::PH_STOP;
      phase_entry_ms <= '0;
      last_frame_ms  <= '0;
      frame_seen     <= 1'b0;
      link_flag      <= 1'b0;
      stored_rpm     <= '0;
      stored_damper  <= '0;
      prev_vtol      <= 1'b0;
      vtol_captured  <= 1'b0;
    end else if (step_en && cfg.enable) begin
      phase          <= ph_next;
      phase_entry_ms <= phase_entry_ms_next;
      last_frame_ms  <= last_frame_ms_next;
      frame_seen     <= frame_seen_next;
      link_flag      <= link_flag_next;
      stored_rpm     <= stored_rpm_next;
      stored_damper  <= stored_damper_next;
      prev_vtol      <= prev_vtol_next;
      vtol_captured  <= vtol_captured_next;
    end
  end

  always_comb begin
    ess_pkg::phase_t ph_rep;
    ph_rep = cfg.enable ? ph_next : phase;
    case (ph_rep)
      ess_pkg::PH_PREPARE: result.engine_phase = ess_pkg::PHASE_CODE_PREPARE;
      ess_pkg::PH_START:   result.engine_phase = ess_pkg::PHASE_CODE_START;
      ess_pkg::PH_RUNNING: result.engine_phase = ess_pkg::PHASE_CODE_RUNNING;
      default:             result.engine_phase = ess_pkg::PHASE_CODE_STOP;
    endcase
    result.throttle_out = cfg.enable ? thr : '0;
    result.starter_on   = cfg.enable && starter;
    result.link_ok      = cfg.enable ? link_flag_next : link_flag;
  end

endmodule

@@ rtl/core/engine_start_sequencer.sv @@
// ----------------------------------------------------------------------------
// engine_start_sequencer
// Engine phase sequencer: stop, prepare, start, running, one result per tick.
// ----------------------------------------------------------------------------
// Latency: a tick accepted on s_tvalid and s_tready passes the input register and
// then the result register before it shows on m_tvalid and m_tdata.
// Throughput: one tick per cycle; the tick step is one pass through the
// input register, the step logic and the result register. A stalled result
// holds the input register, and s_tready stays low while it is full.
// Reset (rst, synchronous): phase stop, telemetry state cleared, configuration
// registers at their defaults with the block disabled, both registers empty.
module engine_start_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [ess_pkg::CfgAddrW-1:0]   wr_addr,
  input  logic [ess_pkg::CfgDataW-1:0]   wr_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // now_ms[31:0], engine_rpm[47:32], damper_pos[63:48], throttle_demand[74:64],
  // vtol_mode[75], armed_flying[76], zero[79:77]
  input  logic [ess_pkg::TdataInW-1:0]   s_tdata,
  // frame_fresh[0], req_type[2:1]
  input  logic [ess_pkg::TuserInW-1:0]   s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // throttle_out[9:0], starter_on[10], engine_phase[12:11], link_ok[13], zero[15:14]
  output logic [ess_pkg::TdataOutW-1:0]  m_tdata
);

  ess_pkg::cfg_t    cfg;
  ess_pkg::item_t   item;
  ess_pkg::result_t result;
  ess_pkg::result_t out_res;
  logic             in_vld;
  logic             advance;

  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.now_ms          <= s_tdata[31:0];
      item.engine_rpm      <= s_tdata[47:32];
      item.damper_pos      <= s_tdata[63:48];
      item.throttle_demand <= s_tdata[74:64];
      item.vtol_mode       <= s_tdata[75];
      item.armed_flying    <= s_tdata[76];
      item.frame_fresh     <= s_tuser[0];
      item.req_type        <= s_tuser[2:1];
    end
  end

  ess_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .cfg     (cfg)
  );

  ess_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .cfg     (cfg),
    .item    (item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tdata = {2'b00, out_res.link_ok, out_res.engine_phase,
                    out_res.starter_on, out_res.throttle_out};

endmodule

@@ rtl/core/ess_checker.sv @@
// ----------------------------------------------------------------------------
// ess_checker
// Port-level checks of the engine start sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ess_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [ess_pkg::TdataOutW-1:0]  m_tdata
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_valid_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(m_tvalid))
    else $error("result valid unknown");

  a_throttle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:0] <= ess_pkg::ThrottleMax))
    else $error("throttle above full scale");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind engine_start_sequencer ess_checker u_ess_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/engine_start_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// engine_start_sequencer_tb
// Self-checking bench for the engine start sequencer. A short directed table
// walks the phase transitions, timeouts, request corner cases and register
// extremes, then random ticks run under several register settings. Every tick
// is scored against an in-bench phase predictor or, in typed directed rows, a
// fixed result, with bursty request traffic and a stalling result side.
// ----------------------------------------------------------------------------
module engine_start_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ReqNone  = 2'd0;
  localparam logic [1:0] ReqUndef = 2'd3;
  localparam int WatchdogCycles = 5000;
  localparam int PlanLen = 6;
  localparam ess_pkg::result_t StopNoLink = '{link_ok: 1'b0,
                                              engine_phase: ess_pkg::PHASE_CODE_STOP,
                                              starter_on: 1'b0, throttle_out: 10'd0};

  typedef enum {RDY_FULL, RDY_COIN, RDY_QUARTER, RDY_SPARSE} rdy_mode_t;

  typedef struct {
    bit                 is_cfg;
    ess_pkg::cfg_idx_t  idx;
    logic [15:0]        val;
    ess_pkg::item_t     tick;
    bit                 typed;
    ess_pkg::result_t   want;
  } row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          wr_en = 1'b0;
  logic [ess_pkg::CfgAddrW-1:0]  wr_addr = '0;
  logic [ess_pkg::CfgDataW-1:0]  wr_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ess_pkg::TdataInW-1:0]  s_tdata = '0;
  logic [ess_pkg::TuserInW-1:0]  s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ess_pkg::TdataOutW-1:0] m_tdata;

  engine_start_sequencer u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predictor state
  ess_pkg::cfg_t regs = '{enable: 1'b0, throttle_min: 10'd0, prepare_timeout_ms: 16'd2000,
                          starter_hold_ms: 16'd2000, link_timeout_ms: 16'd1000,
                          damper_low: 10'd230, damper_high: 10'd270,
                          restart_rpm_limit: 16'd1000};
  logic [1:0]  ph = ess_pkg::PHASE_CODE_STOP;
  logic [31:0] entry_ms = '0;
  logic [31:0] last_frame_ms = '0;
  logic        frame_seen = 1'b0;
  logic        linked = 1'b0;
  logic [15:0] rpm_q = '0;
  logic [15:0] damper_q = '0;
  logic        vtol_q = 1'b0;
  logic        vtol_captured = 1'b0;

  ess_pkg::result_t awaited_cmds[$];
  row_t             ramp_rows[$];
  int               mismatches = 0;
  int               burst_left = 0;
  logic [31:0]      tick_now = '0;
  logic             tick_vtol = 1'b0;

  function automatic void move_to(logic [1:0] p, logic [31:0] now);
    ph = p;
    entry_ms = now;
  endfunction

  function automatic void start_engine(logic [31:0] now);
    if (ph == ess_pkg::PHASE_CODE_PREPARE || ph == ess_pkg::PHASE_CODE_START) return;
    if (!linked || rpm_q < regs.restart_rpm_limit) move_to(ess_pkg::PHASE_CODE_PREPARE, now);
  endfunction

  function automatic void stop_engine(logic [31:0] now);
    if (ph != ess_pkg::PHASE_CODE_STOP) move_to(ess_pkg::PHASE_CODE_STOP, now);
  endfunction

  function automatic void set_reg(ess_pkg::cfg_idx_t idx, logic [15:0] v);
    case (idx)
      ess_pkg::CFG_ENABLE:       regs.enable = v[0];
      ess_pkg::CFG_THROTTLE_MIN: regs.throttle_min = v[9:0];
      ess_pkg::CFG_PREP_TIMEOUT: regs.prepare_timeout_ms = v;
      ess_pkg::CFG_STARTER_HOLD: regs.starter_hold_ms = v;
      ess_pkg::CFG_LINK_TIMEOUT: regs.link_timeout_ms = v;
      ess_pkg::CFG_DAMPER_LOW:   regs.damper_low = v[9:0];
      ess_pkg::CFG_DAMPER_HIGH:  regs.damper_high = v[9:0];
      ess_pkg::CFG_RESTART_RPM:  regs.restart_rpm_limit = v;
      default: ;
    endcase
  endfunction

  function automatic ess_pkg::result_t sequence_tick(ess_pkg::item_t t);
    ess_pkg::result_t r;
    logic [31:0]      elapsed;
    logic [31:0]      age;
    logic [9:0]       tmin;
    int               dem;
    r = '0;
    tmin = (regs.throttle_min > ess_pkg::ThrottleMax) ? ess_pkg::ThrottleMax
                                                      : regs.throttle_min;
    if (regs.enable) begin
      elapsed = t.now_ms - entry_ms;
      case (ph)
        ess_pkg::PHASE_CODE_PREPARE: begin
          r.throttle_out = tmin;
          if (linked && regs.damper_low < damper_q && damper_q < regs.damper_high)
            move_to(ess_pkg::PHASE_CODE_START, t.now_ms);
          if (elapsed > regs.prepare_timeout_ms) move_to(ess_pkg::PHASE_CODE_START, t.now_ms);
        end
        ess_pkg::PHASE_CODE_START: begin
          r.throttle_out = tmin;
          r.starter_on = 1'b1;
          if (elapsed > regs.starter_hold_ms) move_to(ess_pkg::PHASE_CODE_RUNNING, t.now_ms);
        end
        ess_pkg::PHASE_CODE_RUNNING: begin
          dem = $signed(t.throttle_demand);
          if (dem < int'(tmin)) dem = int'(tmin);
          if (dem > int'(ess_pkg::ThrottleMax)) dem = int'(ess_pkg::ThrottleMax);
          r.throttle_out = dem[9:0];
        end
        default: ;
      endcase
      if (t.frame_fresh) begin
        last_frame_ms = t.now_ms;
        frame_seen = 1'b1;
        rpm_q = t.engine_rpm;
        damper_q = t.damper_pos;
      end
      age = t.now_ms - last_frame_ms;
      linked = frame_seen && (age <= regs.link_timeout_ms);
      if (!vtol_captured) begin
        vtol_q = t.vtol_mode;
        vtol_captured = 1'b1;
      end else if (vtol_q != t.vtol_mode) begin
        if (t.armed_flying) begin
          if (t.vtol_mode) stop_engine(t.now_ms);
          else start_engine(t.now_ms);
        end
        vtol_q = t.vtol_mode;
      end
      if (t.req_type == ess_pkg::REQ_START) start_engine(t.now_ms);
      else if (t.req_type == ess_pkg::REQ_STOP) stop_engine(t.now_ms);
    end
    r.engine_phase = ph;
    r.link_ok = linked;
    return r;
  endfunction

  function automatic void add_tick(logic [31:0] now, bit fresh, logic [15:0] rpm,
                                   logic [15:0] damper, int demand, bit vtol, bit armed,
                                   logic [1:0] req, bit typed = 1'b0,
                                   ess_pkg::result_t want = '0);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = ess_pkg::CFG_ENABLE;
    r.val = '0;
    r.tick = '{req_type: req, armed_flying: armed, vtol_mode: vtol,
               throttle_demand: 11'(demand), damper_pos: damper, engine_rpm: rpm,
               frame_fresh: fresh, now_ms: now};
    r.typed = typed;
    r.want = want;
    ramp_rows.push_back(r);
  endfunction

  function automatic void add_cfg(ess_pkg::cfg_idx_t idx, logic [15:0] val);
    row_t r;
    r = '{is_cfg: 1'b1, idx: idx, val: val, tick: '0, typed: 1'b0, want: '0};
    ramp_rows.push_back(r);
  endfunction

  function automatic ess_pkg::item_t random_tick(int unsigned span);
    ess_pkg::item_t t;
    int unsigned    pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) tick_now = $urandom();
    else if (pick < 15) tick_now += $urandom_range(0, 4 * span);
    else tick_now += $urandom_range(0, span);
    if ($urandom_range(0, 19) == 0) tick_vtol = ~tick_vtol;
    t.now_ms = tick_now;
    t.frame_fresh = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1) && regs.restart_rpm_limit != 0)
      t.engine_rpm = 16'($urandom_range(0, regs.restart_rpm_limit - 1));
    else
      t.engine_rpm = 16'($urandom());
    pick = $urandom_range(0, 3);
    if (pick < 2 && regs.damper_high > regs.damper_low + 1)
      t.damper_pos = 16'($urandom_range(regs.damper_low + 1, regs.damper_high - 1));
    else if (pick < 3)
      t.damper_pos = 16'($urandom_range(0, 1023));
    else
      t.damper_pos = 16'($urandom());
    if ($urandom_range(0, 9) == 0) t.throttle_demand = 11'($urandom());
    else t.throttle_demand = 11'(int'($urandom_range(0, 2000)) - 1000);
    t.vtol_mode = tick_vtol;
    t.armed_flying = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 14) t.req_type = ess_pkg::REQ_START;
    else if (pick < 24) t.req_type = ess_pkg::REQ_STOP;
    else if (pick < 27) t.req_type = ReqUndef;
    else t.req_type = ReqNone;
    return t;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic check_cmd(ess_pkg::result_t got);
    ess_pkg::result_t want;
    if (awaited_cmds.size() == 0) begin
      report_mismatch($sformatf("result %h with no request pending", got));
      return;
    end
    want = awaited_cmds.pop_front();
    if (got.throttle_out !== want.throttle_out)
      report_mismatch($sformatf("throttle_out %0d, want %0d", got.throttle_out,
                                want.throttle_out));
    if (got.starter_on !== want.starter_on)
      report_mismatch($sformatf("starter_on %b, want %b", got.starter_on, want.starter_on));
    if (got.engine_phase !== want.engine_phase)
      report_mismatch($sformatf("engine_phase %0d, want %0d", got.engine_phase,
                                want.engine_phase));
    if (got.link_ok !== want.link_ok)
      report_mismatch($sformatf("link_ok %b, want %b", got.link_ok, want.link_ok));
  endtask

  task automatic send_tick(ess_pkg::item_t t, bit typed, ess_pkg::result_t want);
    int               gap;
    ess_pkg::result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, t.armed_flying, t.vtol_mode, t.throttle_demand, t.damper_pos,
                 t.engine_rpm, t.now_ms};
    s_tuser  <= {t.req_type, t.frame_fresh};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = sequence_tick(t);
    awaited_cmds.push_back(typed ? want : r);
  endtask

  task automatic write_reg(ess_pkg::cfg_idx_t idx, logic [15:0] val);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en   <= 1'b1;
    wr_addr <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    set_reg(idx, val);
  endtask

  task automatic apply_settings(ess_pkg::cfg_t c);
    write_reg(ess_pkg::CFG_THROTTLE_MIN, 16'(c.throttle_min));
    write_reg(ess_pkg::CFG_PREP_TIMEOUT, c.prepare_timeout_ms);
    write_reg(ess_pkg::CFG_STARTER_HOLD, c.starter_hold_ms);
    write_reg(ess_pkg::CFG_LINK_TIMEOUT, c.link_timeout_ms);
    write_reg(ess_pkg::CFG_DAMPER_LOW, 16'(c.damper_low));
    write_reg(ess_pkg::CFG_DAMPER_HIGH, 16'(c.damper_high));
    write_reg(ess_pkg::CFG_RESTART_RPM, c.restart_rpm_limit);
    write_reg(ess_pkg::CFG_ENABLE, 16'(c.enable));
  endtask

  // result side: score and stall
  rdy_mode_t rdy_mode = RDY_FULL;
  int        rdy_left = 0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_cmd(ess_pkg::result_t'(m_tdata[13:0]));
    if (rdy_left == 0) begin
      rdy_mode = rdy_mode_t'($urandom_range(0, 3));
      rdy_left = $urandom_range(20, 200);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      RDY_FULL:    m_tready <= 1'b1;
      RDY_COIN:    m_tready <= 1'($urandom_range(0, 1));
      RDY_QUARTER: m_tready <= (rdy_left % 4 == 0);
      default:     m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WatchdogCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    ess_pkg::cfg_t plan[PlanLen];
    int            plan_items[PlanLen];
    int unsigned   span;

    add_tick(32'd100, 1, 16'hFFFF, 16'hFFFF, 1023, 1, 1, ess_pkg::REQ_START, 1, StopNoLink);
    add_tick(32'd200, 0, 16'd0, 16'd0, -1024, 0, 0, ReqUndef, 1, StopNoLink);
    add_cfg(ess_pkg::CFG_ENABLE, 16'd1);
    add_tick(32'd0, 0, 16'd0, 16'd0, 0, 0, 0, ReqNone, 1, StopNoLink);
    add_tick(32'd10, 1, 16'd500, 16'd250, 0, 0, 0, ess_pkg::REQ_START);
    add_tick(32'd20, 0, 16'd0, 16'd0, 0, 0, 0, ReqNone);
    add_tick(32'd2021, 0, 16'd0, 16'd0, 500, 0, 0, ReqNone);
    add_tick(32'd2022, 0, 16'd0, 16'd0, 1023, 0, 0, ReqNone);
    add_tick(32'd2023, 0, 16'd0, 16'd0, -1024, 0, 0, ReqNone);
    add_tick(32'd2024, 0, 16'd0, 16'd0, 0, 1, 1, ReqNone);
    add_tick(32'd2025, 0, 16'd0, 16'd0, 0, 0, 1, ReqNone);
    add_tick(32'd2030, 0, 16'd0, 16'd0, 0, 0, 0, ess_pkg::REQ_START);
    add_tick(32'd4026, 0, 16'd0, 16'd0, 0, 0, 0, ReqNone);
    add_tick(32'd4027, 0, 16'd0, 16'd0, 0, 0, 0, ess_pkg::REQ_START);
    add_tick(32'd4028, 0, 16'd0, 16'd0, 0, 0, 0, ess_pkg::REQ_STOP);
    add_tick(32'd4029, 0, 16'd0, 16'd0, 0, 0, 0, ess_pkg::REQ_STOP);
    add_tick(32'd4030, 1, 16'hFFFF, 16'd0, 0, 0, 0, ess_pkg::REQ_START);
    add_tick(32'd4031, 0, 16'd0, 16'd0, 0, 1, 0, ReqNone);
    add_tick(32'hFFFF_FFF0, 1, 16'd0, 16'd1023, 0, 1, 0, ess_pkg::REQ_START);
    add_tick(32'h0000_0010, 0, 16'd0, 16'd0, 0, 1, 0, ReqNone);
    add_cfg(ess_pkg::CFG_THROTTLE_MIN, 16'd1023);
    add_tick(32'h0000_07E0, 0, 16'd0, 16'd0, 0, 1, 0, ReqNone);
    add_cfg(ess_pkg::CFG_STARTER_HOLD, 16'd0);
    add_tick(32'h0000_07E1, 0, 16'd0, 16'd0, 0, 1, 0, ReqNone);
    add_tick(32'h0000_07E2, 0, 16'd0, 16'd0, -1000, 1, 0, ReqNone);
    add_tick(32'h0000_07E3, 0, 16'd0, 16'd0, 0, 0, 1, ess_pkg::REQ_STOP);

    plan[0] = '{enable: 1'b1, throttle_min: 10'd100, prepare_timeout_ms: 16'd30,
                starter_hold_ms: 16'd20, link_timeout_ms: 16'd15, damper_low: 10'd230,
                damper_high: 10'd270, restart_rpm_limit: 16'd1000};
    plan[1] = '{enable: 1'b1, throttle_min: 10'd1023, prepare_timeout_ms: 16'd0,
                starter_hold_ms: 16'd0, link_timeout_ms: 16'd0, damper_low: 10'd0,
                damper_high: 10'd1023, restart_rpm_limit: 16'hFFFF};
    plan[2] = '{enable: 1'b0, throttle_min: 10'd500, prepare_timeout_ms: 16'd10,
                starter_hold_ms: 16'd10, link_timeout_ms: 16'd10, damper_low: 10'd100,
                damper_high: 10'd900, restart_rpm_limit: 16'd2000};
    plan[3] = '{enable: 1'b1, throttle_min: 10'd0, prepare_timeout_ms: 16'hFFFF,
                starter_hold_ms: 16'hFFFF, link_timeout_ms: 16'hFFFF, damper_low: 10'd1023,
                damper_high: 10'd0, restart_rpm_limit: 16'd0};
    plan[4] = '{enable: 1'b1, throttle_min: 10'($urandom_range(0, 1023)),
                prepare_timeout_ms: 16'($urandom_range(0, 300)),
                starter_hold_ms: 16'($urandom_range(0, 300)),
                link_timeout_ms: 16'($urandom_range(0, 300)),
                damper_low: 10'($urandom_range(0, 500)),
                damper_high: 10'($urandom_range(400, 1023)),
                restart_rpm_limit: 16'($urandom())};
    plan[5] = '{enable: 1'b1, throttle_min: 10'd1000, prepare_timeout_ms: 16'd5,
                starter_hold_ms: 16'd40, link_timeout_ms: 16'd3, damper_low: 10'd400,
                damper_high: 10'd600, restart_rpm_limit: 16'd30000};
    plan_items = '{100, 100, 30, 100, 100, 100};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (ramp_rows[i]) begin
      if (ramp_rows[i].is_cfg) write_reg(ramp_rows[i].idx, ramp_rows[i].val);
      else send_tick(ramp_rows[i].tick, ramp_rows[i].typed, ramp_rows[i].want);
    end
    tick_now = 32'h0000_07E3;
    tick_vtol = 1'b0;

    for (int p = 0; p < PlanLen; p++) begin
      apply_settings(plan[p]);
      span = plan[p].prepare_timeout_ms;
      if (plan[p].starter_hold_ms > span) span = plan[p].starter_hold_ms;
      if (plan[p].link_timeout_ms > span) span = plan[p].link_timeout_ms;
      span = span / 4 + 4;
      for (int n = 0; n < plan_items[p]; n++) send_tick(random_tick(span), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (awaited_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
